// ===== rtl/linked_list_cursor_manager_macros.svh =====
// Assertion helpers for the checker file.
`ifndef LINKED_LIST_CURSOR_MANAGER_MACROS_SVH
`define LINKED_LIST_CURSOR_MANAGER_MACROS_SVH

// Same-cycle implication, sampled on the block clock, idle in reset.
`define LLCM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("llcm assertion failed");

// Next-cycle implication, sampled on the block clock, idle in reset.
`define LLCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("llcm assertion failed");

`endif

// ===== rtl/llcm_pkg.sv =====
package llcm_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned MODE_W       = 4;

  typedef enum logic [3:0] {
    MODE_INS_AFTER = 4'd0,
    MODE_INS_FRONT = 4'd1,
    MODE_DEL_AFTER = 4'd2,
    MODE_DEL_CUR   = 4'd3,
    MODE_SWAP_NEXT = 4'd4,
    MODE_SWAP_PREV = 4'd5,
    MODE_SEARCH    = 4'd6,
    MODE_CLEAR     = 4'd7,
    MODE_NEXT      = 4'd8,
    MODE_PREV      = 4'd9,
    MODE_HEAD      = 4'd10
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_NBR   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OUTC_NONE   = 2'd0,
    OUTC_BELOW  = 2'd1,
    OUTC_FOUND  = 2'd2,
    OUTC_ABSENT = 2'd3
  } outcome_e;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_DEC,
    ST_INS_B,
    ST_INS_C,
    ST_DEL_B,
    ST_DEL_C,
    ST_DEL_D,
    ST_SWP_B,
    ST_SWP_C,
    ST_SRCH,
    ST_DONE,
    ST_OUT
  } state_e;

endpackage

// ===== rtl/llcm_ram.sv =====
module llcm_ram
  import llcm_pkg::*;
#(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = CAPACITY_DEF,
  localparam int unsigned IW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [IW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/llcm_cmp.sv =====
module llcm_cmp
  import llcm_pkg::*;
(
  input  logic signed [VAL_W-1:0] a_i,
  input  logic signed [VAL_W-1:0] b_i,
  output logic                    lt_o,
  output logic                    eq_o
);

  // signed order on the keys
  assign lt_o = (a_i < b_i);
  assign eq_o = (a_i == b_i);

endmodule

// ===== rtl/linked_list_cursor_manager.sv =====
// Linked list with cursor. A doubly linked list of up to CAPACITY nodes lives in four
// single-port-read memories (next link, previous link, value, key) with a singly linked
// free list and a cursor. Each input word carries one command; each command answers with
// exactly one output word holding the status, the search outcome and the node under the
// cursor afterwards. A small sequencer drives the memories, one registered read per memory
// and cycle, and a single key comparator serves the search. A search walks the list from
// the head and visits at most CAPACITY nodes; clear reruns the link re-initialization
// sweep. After reset the same sweep runs with the input held not ready. The block takes
// one command at a time; a finished word waits in the output register while the next
// command is accepted.
module linked_list_cursor_manager
  import llcm_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode[3:0], item_value[35:4], item_key[67:36], zero fill
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], search_outcome[3:2], cursor_valid[4], cursor_value[36:5],
  // cursor_key[68:37], zero fill
  output logic [71:0] m_axis_tdata
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned AW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] NIL = AW'(CAPACITY);

  state_e state_q, state_d;

  // captured command word
  logic [MODE_W-1:0] mode_q, mode_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic [VAL_W-1:0]  key_q, key_d;

  // list control registers
  logic [AW-1:0] head_q, head_d, tail_q, tail_d, cur_q, cur_d, free_q, free_d;

  // scratch: neighbor after the cursor, target node, unlink neighbors
  logic [AW-1:0] nq_q, nq_d, t_q, t_d, lp_q, lp_d, lq_q, lq_d;
  logic [VAL_W-1:0] cv_q, cv_d;
  logic          first_q, first_d;
  logic          cmd_q, cmd_d;
  logic [IW-1:0] clr_q, clr_d;
  status_e       st_q, st_d;
  outcome_e      oc_q, oc_d;

  // output register
  logic             ov_q, ov_d;
  status_e          ost_q, ost_d;
  outcome_e         ooc_q, ooc_d;
  logic             ocv_q, ocv_d;
  logic [VAL_W-1:0] oval_q, oval_d, okey_q, okey_d;

  // memory ports
  logic          nx_we, pv_we, vl_we, ky_we;
  logic [AW-1:0] nx_wa, pv_wa, vl_wa, ky_wa;
  logic [AW-1:0] nx_ra, pv_ra, vl_ra, ky_ra;
  logic [AW-1:0] nx_wd, pv_wd;
  logic [VAL_W-1:0] vl_wd, ky_wd;
  logic [AW-1:0] nx_rd, pv_rd;
  logic [VAL_W-1:0] vl_rd, ky_rd;

  logic key_lt, key_eq;
  logic in_acc, empty, out_free;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign empty    = (head_q == NIL);
  assign out_free = !ov_q || m_axis_tready;

  llcm_ram #(.W(AW), .DEPTH(CAPACITY)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_wa[IW-1:0]), .wdata_i(nx_wd),
    .raddr_i(nx_ra[IW-1:0]), .rdata_o(nx_rd)
  );
  llcm_ram #(.W(AW), .DEPTH(CAPACITY)) u_prev (
    .clk_i, .we_i(pv_we), .waddr_i(pv_wa[IW-1:0]), .wdata_i(pv_wd),
    .raddr_i(pv_ra[IW-1:0]), .rdata_o(pv_rd)
  );
  llcm_ram #(.W(VAL_W), .DEPTH(CAPACITY)) u_value (
    .clk_i, .we_i(vl_we), .waddr_i(vl_wa[IW-1:0]), .wdata_i(vl_wd),
    .raddr_i(vl_ra[IW-1:0]), .rdata_o(vl_rd)
  );
  llcm_ram #(.W(VAL_W), .DEPTH(CAPACITY)) u_key (
    .clk_i, .we_i(ky_we), .waddr_i(ky_wa[IW-1:0]), .wdata_i(ky_wd),
    .raddr_i(ky_ra[IW-1:0]), .rdata_o(ky_rd)
  );

  // the one comparator: searched key against the key just read
  llcm_cmp u_cmp (
    .a_i(key_q), .b_i(ky_rd), .lt_o(key_lt), .eq_o(key_eq)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLR: begin
        if (clr_q == IW'(CAPACITY - 1)) state_d = cmd_q ? ST_DONE : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_d = ST_DEC;
      end
      ST_DEC: begin
        if (mode_q == MODE_INS_AFTER || mode_q == MODE_INS_FRONT) begin
          state_d = (free_q != NIL) ? ST_INS_B : ST_DONE;
        end else if (mode_q == MODE_CLEAR) begin
          state_d = ST_CLR;
        end else if (mode_q > MODE_HEAD || empty) begin
          state_d = ST_DONE;
        end else begin
          unique case (mode_q)
            MODE_DEL_AFTER: state_d = (nx_rd == NIL) ? ST_DONE : ST_DEL_B;
            MODE_DEL_CUR:   state_d = ST_DEL_C;
            MODE_SWAP_NEXT: state_d = (nx_rd == NIL) ? ST_DONE : ST_SWP_B;
            MODE_SWAP_PREV: state_d = (pv_rd == NIL) ? ST_DONE : ST_SWP_B;
            MODE_SEARCH:    state_d = ST_SRCH;
            default:        state_d = ST_DONE;
          endcase
        end
      end
      ST_INS_B: state_d = empty ? ST_DONE : ST_INS_C;
      ST_INS_C: state_d = ST_DONE;
      ST_DEL_B: state_d = ST_DEL_C;
      ST_DEL_C: state_d = ST_DEL_D;
      ST_DEL_D: state_d = ST_DONE;
      ST_SWP_B: state_d = ST_SWP_C;
      ST_SWP_C: state_d = ST_DONE;
      ST_SRCH: begin
        if ((first_q && key_lt) || key_eq || key_lt || nx_rd == NIL) state_d = ST_DONE;
      end
      ST_DONE: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    mode_d = mode_q; val_d = val_q; key_d = key_q;
    head_d = head_q; tail_d = tail_q; cur_d = cur_q; free_d = free_q;
    nq_d = nq_q; t_d = t_q; lp_d = lp_q; lq_d = lq_q;
    cv_d = cv_q; first_d = first_q; cmd_d = cmd_q; clr_d = clr_q;
    st_d = st_q; oc_d = oc_q;
    ost_d = ost_q; ooc_d = ooc_q; ocv_d = ocv_q; oval_d = oval_q; okey_d = okey_q;
    ov_d = ov_q && !m_axis_tready;

    nx_we = 1'b0; pv_we = 1'b0; vl_we = 1'b0; ky_we = 1'b0;
    nx_wa = cur_q; pv_wa = cur_q; vl_wa = cur_q; ky_wa = cur_q;
    nx_wd = NIL; pv_wd = NIL; vl_wd = val_q; ky_wd = key_q;
    // read at the cursor unless a state points elsewhere
    nx_ra = cur_q; pv_ra = cur_q; vl_ra = cur_q; ky_ra = cur_q;

    unique case (state_q)
      ST_CLR: begin
        // rebuild the free chain: entry i links i+1, the last one lands on null
        nx_we = 1'b1; nx_wa = AW'(clr_q); nx_wd = AW'(clr_q) + AW'(1);
        pv_we = 1'b1; pv_wa = AW'(clr_q); pv_wd = NIL;
        clr_d = clr_q + 1'b1;
        head_d = NIL; tail_d = NIL; cur_d = NIL; free_d = '0;
        if (clr_q == IW'(CAPACITY - 1)) cmd_d = 1'b0;
      end
      ST_IDLE: begin
        if (in_acc) begin
          mode_d  = s_axis_tdata[3:0];
          val_d   = s_axis_tdata[35:4];
          key_d   = s_axis_tdata[67:36];
          st_d    = STAT_OK;
          oc_d    = OUTC_NONE;
          first_d = 1'b1;
        end
      end
      ST_DEC: begin
        // cursor links and payload arrive from the reads issued while idle
        nq_d = nx_rd; cv_d = vl_rd;
        if (mode_q == MODE_INS_AFTER || mode_q == MODE_INS_FRONT) begin
          if (free_q != NIL) begin
            t_d = free_q;
            vl_we = 1'b1; vl_wa = free_q;
            ky_we = 1'b1; ky_wa = free_q;
            nx_ra = free_q;
          end else begin
            st_d = STAT_FULL;
          end
        end else if (mode_q == MODE_CLEAR) begin
          cmd_d = 1'b1; clr_d = '0;
          head_d = NIL; tail_d = NIL; cur_d = NIL; free_d = '0;
        end else if (mode_q > MODE_HEAD) begin
          st_d = STAT_OK;
        end else if (empty) begin
          st_d = STAT_EMPTY;
        end else begin
          unique case (mode_q)
            MODE_DEL_AFTER: begin
              if (nx_rd == NIL) st_d = STAT_NBR;
              else begin
                t_d = nx_rd; lp_d = cur_q; nx_ra = nx_rd;
              end
            end
            MODE_DEL_CUR: begin
              t_d = cur_q; lp_d = pv_rd; lq_d = nx_rd;
              cur_d = (pv_rd != NIL) ? pv_rd : nx_rd;
            end
            MODE_SWAP_NEXT: begin
              if (nx_rd == NIL) st_d = STAT_NBR;
              else begin
                t_d = nx_rd; vl_ra = nx_rd;
              end
            end
            MODE_SWAP_PREV: begin
              if (pv_rd == NIL) st_d = STAT_NBR;
              else begin
                t_d = pv_rd; vl_ra = pv_rd;
              end
            end
            MODE_SEARCH: begin
              t_d = head_q;
              nx_ra = head_q; pv_ra = head_q; ky_ra = head_q;
            end
            MODE_NEXT: begin
              if (nx_rd == NIL) st_d = STAT_NBR;
              else cur_d = nx_rd;
            end
            MODE_PREV: begin
              if (pv_rd == NIL) st_d = STAT_NBR;
              else cur_d = pv_rd;
            end
            default: cur_d = head_q;
          endcase
        end
      end
      ST_INS_B: begin
        // pop the free head, then hook the new node in
        free_d = nx_rd;
        nx_we = 1'b1; nx_wa = t_q;
        pv_we = 1'b1; pv_wa = t_q;
        if (empty) begin
          nx_wd = NIL; pv_wd = NIL;
          head_d = t_q; tail_d = t_q; cur_d = t_q;
        end else if (mode_q == MODE_INS_AFTER) begin
          nx_wd = nq_q; pv_wd = cur_q;
        end else begin
          nx_wd = head_q; pv_wd = NIL;
        end
      end
      ST_INS_C: begin
        if (mode_q == MODE_INS_AFTER) begin
          nx_we = 1'b1; nx_wa = cur_q; nx_wd = t_q;
          if (nq_q != NIL) begin
            pv_we = 1'b1; pv_wa = nq_q; pv_wd = t_q;
          end else begin
            tail_d = t_q;
          end
        end else begin
          pv_we = 1'b1; pv_wa = head_q; pv_wd = t_q;
          head_d = t_q;
        end
      end
      ST_DEL_B: lq_d = nx_rd;
      ST_DEL_C: begin
        // bridge the neighbors around the target
        if (lp_q != NIL) begin
          nx_we = 1'b1; nx_wa = lp_q; nx_wd = lq_q;
        end else begin
          head_d = lq_q;
        end
        if (lq_q != NIL) begin
          pv_we = 1'b1; pv_wa = lq_q; pv_wd = lp_q;
        end else begin
          tail_d = lp_q;
        end
      end
      ST_DEL_D: begin
        // push the freed node onto the free list
        nx_we = 1'b1; nx_wa = t_q; nx_wd = free_q;
        pv_we = 1'b1; pv_wa = t_q; pv_wd = NIL;
        free_d = t_q;
      end
      ST_SWP_B: begin
        vl_we = 1'b1; vl_wa = cur_q; vl_wd = vl_rd;
      end
      ST_SWP_C: begin
        vl_we = 1'b1; vl_wa = t_q; vl_wd = cv_q;
      end
      ST_SRCH: begin
        // key, links of node t_q are on the read ports
        first_d = 1'b0;
        if (first_q && key_lt) begin
          oc_d = OUTC_BELOW; cur_d = t_q;
        end else if (key_eq) begin
          oc_d = OUTC_FOUND; cur_d = t_q;
        end else if (key_lt) begin
          oc_d = OUTC_ABSENT; cur_d = pv_rd;
        end else if (nx_rd == NIL) begin
          oc_d = OUTC_ABSENT; cur_d = tail_q;
        end else begin
          t_d = nx_rd;
          nx_ra = nx_rd; pv_ra = nx_rd; ky_ra = nx_rd;
        end
      end
      ST_DONE: begin
        // reads at the final cursor are issued by default
      end
      ST_OUT: begin
        if (out_free) begin
          ov_d   = 1'b1;
          ost_d  = st_q;
          ooc_d  = oc_q;
          ocv_d  = (cur_q != NIL);
          oval_d = (cur_q != NIL) ? vl_rd : '0;
          okey_d = (cur_q != NIL) ? ky_rd : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      head_q  <= NIL;
      tail_q  <= NIL;
      cur_q   <= NIL;
      free_q  <= '0;
      clr_q   <= '0;
      cmd_q   <= 1'b0;
      first_q <= 1'b0;
      ov_q    <= 1'b0;
      st_q    <= STAT_OK;
      oc_q    <= OUTC_NONE;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cur_q   <= cur_d;
      free_q  <= free_d;
      clr_q   <= clr_d;
      cmd_q   <= cmd_d;
      first_q <= first_d;
      ov_q    <= ov_d;
      st_q    <= st_d;
      oc_q    <= oc_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    val_q  <= val_d;
    key_q  <= key_d;
    nq_q   <= nq_d;
    t_q    <= t_d;
    lp_q   <= lp_d;
    lq_q   <= lq_d;
    cv_q   <= cv_d;
    ost_q  <= ost_d;
    ooc_q  <= ooc_d;
    ocv_q  <= ocv_d;
    oval_q <= oval_d;
    okey_q <= okey_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {3'b000, okey_q, oval_q, ocv_q, ooc_q, ost_q};

endmodule

// ===== rtl/llcm_checker.sv =====
`include "linked_list_cursor_manager_macros.svh"

module llcm_checker
  import llcm_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [71:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  // a waiting word stays offered
  `LLCM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // no cursor node means zero payload fields
  `LLCM_ASSERT_NOW(a_nocur_zero, m_axis_tvalid && !m_axis_tdata[4], m_axis_tdata[68:5] == '0)

  // a search outcome only comes with an ok status
  `LLCM_ASSERT_NOW(a_outc_ok, m_axis_tvalid && m_axis_tdata[3:2] != OUTC_NONE,
                   m_axis_tdata[1:0] == STAT_OK)

  // a full list has a cursor node
  `LLCM_ASSERT_NOW(a_full_cur, m_axis_tvalid && m_axis_tdata[1:0] == STAT_FULL,
                   m_axis_tdata[4])

endmodule

bind linked_list_cursor_manager llcm_checker u_llcm_checker (.*);
